### hw/rtl/sbhs_pkg.sv
// Package for the SPI bootloader host sequencer: phase codes, protocol bytes,
// operation codes and the command code table. No dependencies.
package sbhs_pkg;

    localparam int unsigned MaxTransfer = 256;

    localparam logic [7:0] SofByte = 8'h5A;
    localparam logic [7:0] AckByte = 8'h79;
    localparam logic [7:0] NakByte = 8'h1F;
    localparam logic [15:0] SpecialErase = 16'hFFF0;
    localparam logic [15:0] MassErase = 16'hFFFF;

    localparam logic [1:0] ActStart = 2'd0;
    localparam logic [1:0] ActPayload = 2'd1;
    localparam logic [1:0] ActRx = 2'd2;

    localparam logic [3:0] OpConnect = 4'd0;
    localparam logic [3:0] OpGet = 4'd1;
    localparam logic [3:0] OpVersion = 4'd2;
    localparam logic [3:0] OpId = 4'd3;
    localparam logic [3:0] OpRead = 4'd4;
    localparam logic [3:0] OpGo = 4'd5;
    localparam logic [3:0] OpWrite = 4'd6;
    localparam logic [3:0] OpErase = 4'd7;
    localparam logic [3:0] OpWprot = 4'd8;
    localparam logic [3:0] OpWunprot = 4'd9;
    localparam logic [3:0] OpRprot = 4'd10;
    localparam logic [3:0] OpRunprot = 4'd11;
    localparam logic [3:0] OpLast = 4'd11;

    localparam logic [1:0] StOk = 2'd0;
    localparam logic [1:0] StErr = 2'd1;
    localparam logic [1:0] StTmo = 2'd2;

    localparam logic [0:0] CfgAckLimit = 1'd0;
    localparam logic [0:0] CfgConnLimit = 1'd1;

    typedef enum logic [19:0] {
        PH_IDLE      = 20'd1 << 0,
        PH_SYNC      = 20'd1 << 1,
        PH_CMD       = 20'd1 << 2,
        PH_ADDR      = 20'd1 << 3,
        PH_LEN2      = 20'd1 << 4,
        PH_ECNT      = 20'd1 << 5,
        PH_ACK_DUMMY = 20'd1 << 6,
        PH_ACK_POLL  = 20'd1 << 7,
        PH_ACK_OK    = 20'd1 << 8,
        PH_ACK_NAK   = 20'd1 << 9,
        PH_ACK_TMO   = 20'd1 << 10,
        PH_PRE_DUMMY = 20'd1 << 11,
        PH_CNT_RX    = 20'd1 << 12,
        PH_DATA_RX   = 20'd1 << 13,
        PH_WR_N      = 20'd1 << 14,
        PH_WAIT_PAY  = 20'd1 << 15,
        PH_WR_DATA   = 20'd1 << 16,
        PH_PG_HI     = 20'd1 << 17,
        PH_PG_LO     = 20'd1 << 18,
        PH_CSUM      = 20'd1 << 19
    } t_phase;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  operation;
        logic [31:0] address;
        logic [8:0]  length;
        logic        wipe_all;
        logic [15:0] data_word;
        logic [7:0]  rx_byte;
    } t_in_item;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       payload_request;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       done_res;
        logic [1:0] status;
    } t_out_item;

    function automatic logic [7:0] cmd_code(input logic [3:0] op);
        logic [7:0] c;
        case (op)
            OpVersion: c = 8'h01;
            OpId: c = 8'h02;
            OpRead: c = 8'h11;
            OpGo: c = 8'h21;
            OpWrite: c = 8'h31;
            OpErase: c = 8'h44;
            OpWprot: c = 8'h63;
            OpWunprot: c = 8'h73;
            OpRprot: c = 8'h82;
            OpRunprot: c = 8'h92;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic ack_is_last(input logic [3:0] op, input logic [2:0] ord);
        logic r;
        case (op)
            OpConnect: r = (ord == 3'd0);
            OpRead: r = 1'b0;
            OpWrite, OpErase, OpWprot: r = (ord == 3'd2);
            default: r = (ord == 3'd1);
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/sbhs_if.sv
// Valid/ready channel interface carrying one item of type T.
// Does not itself depend on sbhs_pkg; the payload type is given by T.
interface sbhs_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/sbhs_core.sv
// Next-state and result logic of the sequencer for one accepted item.
// Depends on sbhs_pkg.
module sbhs_core #(
    parameter int unsigned MAX_TRANSFER = sbhs_pkg::MaxTransfer
) (
    input  sbhs_pkg::t_in_item  i_item,
    input  sbhs_pkg::t_phase    i_phase,
    input  logic [3:0]          i_op,
    input  logic [31:0]         i_addr,
    input  logic [8:0]          i_left,
    input  logic [2:0]          i_fidx,
    input  logic [7:0]          i_xor,
    input  logic [31:0]         i_att,
    input  logic [31:0]         i_ack_lim,
    input  logic [31:0]         i_conn_lim,
    output sbhs_pkg::t_phase    o_phase,
    output logic [3:0]          o_op,
    output logic [31:0]         o_addr,
    output logic [8:0]          o_left,
    output logic [2:0]          o_fidx,
    output logic [7:0]          o_xor,
    output logic [31:0]         o_att,
    output logic                o_has,
    output sbhs_pkg::t_out_item o_out
);
    localparam logic [9:0] MaxLen = 10'(MAX_TRANSFER);

    logic [7:0]  rx;
    logic [7:0]  code;
    logic [15:0] w16;
    logic [2:0]  fnext;
    logic        bad_len;
    logic        last;

    always_comb begin
        rx = i_item.rx_byte;
        code = sbhs_pkg::cmd_code(i_op);
        w16 = i_addr[15:0];
        fnext = i_fidx + 3'd1;
        bad_len = (i_item.length == 9'd0) || ({1'b0, i_item.length} > MaxLen);
        last = sbhs_pkg::ack_is_last(i_op, i_fidx);

        o_phase = i_phase;
        o_op = i_op;
        o_addr = i_addr;
        o_left = i_left;
        o_fidx = i_fidx;
        o_xor = i_xor;
        o_att = i_att;
        o_has = 1'b0;
        o_out = '0;

        case (i_item.action)
            sbhs_pkg::ActStart: begin
                o_has = 1'b1;
                o_op = i_item.operation;
                o_addr = i_item.address;
                o_left = i_item.length;
                o_xor = '0;
                o_fidx = '0;
                if (i_item.operation > sbhs_pkg::OpLast
                        || ((i_item.operation == sbhs_pkg::OpRead
                             || i_item.operation == sbhs_pkg::OpWrite
                             || i_item.operation == sbhs_pkg::OpWprot) && bad_len)
                        || (i_item.operation == sbhs_pkg::OpErase
                            && !i_item.wipe_all && bad_len)) begin
                    o_out.done_res = 1'b1;
                    o_out.status = sbhs_pkg::StErr;
                    o_phase = sbhs_pkg::PH_IDLE;
                end else begin
                    if (i_item.operation == sbhs_pkg::OpErase) begin
                        o_addr = i_item.wipe_all ? {16'd0, sbhs_pkg::MassErase}
                                                 : {23'd0, i_item.length - 9'd1};
                    end
                    o_phase = (i_item.operation == sbhs_pkg::OpConnect)
                              ? sbhs_pkg::PH_SYNC : sbhs_pkg::PH_CMD;
                    o_out.tx_valid = 1'b1;
                    o_out.tx_byte = sbhs_pkg::SofByte;
                end
            end
            sbhs_pkg::ActPayload: begin
                if (i_phase == sbhs_pkg::PH_WAIT_PAY) begin
                    o_has = 1'b1;
                    o_out.tx_valid = 1'b1;
                    if (i_op == sbhs_pkg::OpErase) begin
                        o_addr = {16'd0, i_item.data_word};
                        o_xor = i_xor ^ i_item.data_word[15:8] ^ i_item.data_word[7:0];
                        o_phase = sbhs_pkg::PH_PG_HI;
                        o_out.tx_byte = i_item.data_word[15:8];
                    end else begin
                        o_xor = i_xor ^ i_item.data_word[7:0];
                        o_phase = sbhs_pkg::PH_WR_DATA;
                        o_out.tx_byte = i_item.data_word[7:0];
                    end
                end
            end
            sbhs_pkg::ActRx: begin
                if (i_phase != sbhs_pkg::PH_IDLE && i_phase != sbhs_pkg::PH_WAIT_PAY) begin
                    o_has = 1'b1;
                    o_out.tx_valid = 1'b1;
                    unique case (i_phase)
                        sbhs_pkg::PH_SYNC: begin
                            o_fidx = 3'd0;
                            o_att = (i_conn_lim != 0) ? i_conn_lim : 32'd1;
                            o_phase = sbhs_pkg::PH_ACK_DUMMY;
                        end
                        sbhs_pkg::PH_CMD: begin
                            if (i_fidx < 3'd2) begin
                                o_out.tx_byte = (i_fidx == 3'd0) ? code : ~code;
                                o_fidx = fnext;
                            end else begin
                                o_fidx = 3'd0;
                                o_att = (i_ack_lim != 0) ? i_ack_lim : 32'd1;
                                o_phase = sbhs_pkg::PH_ACK_DUMMY;
                            end
                        end
                        sbhs_pkg::PH_ADDR: begin
                            o_fidx = fnext;
                            if (fnext == 3'd1) o_out.tx_byte = i_addr[23:16];
                            else if (fnext == 3'd2) o_out.tx_byte = i_addr[15:8];
                            else if (fnext == 3'd3) o_out.tx_byte = i_addr[7:0];
                            else if (fnext == 3'd4)
                                o_out.tx_byte = i_addr[31:24] ^ i_addr[23:16]
                                                ^ i_addr[15:8] ^ i_addr[7:0];
                            else begin
                                o_fidx = 3'd1;
                                o_att = (i_ack_lim != 0) ? i_ack_lim : 32'd1;
                                o_phase = sbhs_pkg::PH_ACK_DUMMY;
                            end
                        end
                        sbhs_pkg::PH_LEN2: begin
                            if (i_fidx == 3'd0) begin
                                o_fidx = 3'd1;
                                o_out.tx_byte = ~(i_left[7:0] - 8'd1);
                            end else begin
                                o_fidx = (i_op == sbhs_pkg::OpRead) ? 3'd2 : 3'd1;
                                o_att = (i_ack_lim != 0) ? i_ack_lim : 32'd1;
                                o_phase = sbhs_pkg::PH_ACK_DUMMY;
                            end
                        end
                        sbhs_pkg::PH_ECNT: begin
                            o_fidx = fnext;
                            if (fnext == 3'd1) o_out.tx_byte = w16[7:0];
                            else if (fnext == 3'd2) o_out.tx_byte = w16[15:8] ^ w16[7:0];
                            else begin
                                o_fidx = (w16 >= sbhs_pkg::SpecialErase) ? 3'd2 : 3'd1;
                                o_att = (i_ack_lim != 0) ? i_ack_lim : 32'd1;
                                o_phase = sbhs_pkg::PH_ACK_DUMMY;
                            end
                        end
                        sbhs_pkg::PH_ACK_DUMMY: o_phase = sbhs_pkg::PH_ACK_POLL;
                        sbhs_pkg::PH_ACK_POLL: begin
                            if (rx == sbhs_pkg::AckByte) begin
                                o_phase = sbhs_pkg::PH_ACK_OK;
                            end else if (rx == sbhs_pkg::NakByte) begin
                                o_phase = sbhs_pkg::PH_ACK_NAK;
                            end else begin
                                o_att = (i_att != 0) ? i_att - 32'd1 : i_att;
                                if (i_att <= 32'd1) o_phase = sbhs_pkg::PH_ACK_TMO;
                            end
                            o_out.tx_byte = (o_phase == sbhs_pkg::PH_ACK_POLL)
                                            ? 8'h00 : sbhs_pkg::AckByte;
                        end
                        sbhs_pkg::PH_ACK_OK: begin
                            if (last) begin
                                o_out = '0;
                                o_out.done_res = 1'b1;
                                o_out.status = sbhs_pkg::StOk;
                                o_phase = sbhs_pkg::PH_IDLE;
                            end else if (i_fidx == 3'd0) begin
                                if (i_op <= sbhs_pkg::OpId) begin
                                    o_phase = sbhs_pkg::PH_PRE_DUMMY;
                                end else if (i_op == sbhs_pkg::OpRead || i_op == sbhs_pkg::OpGo
                                             || i_op == sbhs_pkg::OpWrite) begin
                                    o_phase = sbhs_pkg::PH_ADDR;
                                    o_out.tx_byte = i_addr[31:24];
                                end else if (i_op == sbhs_pkg::OpErase) begin
                                    o_phase = sbhs_pkg::PH_ECNT;
                                    o_out.tx_byte = i_addr[15:8];
                                end else if (i_op == sbhs_pkg::OpWprot) begin
                                    o_phase = sbhs_pkg::PH_LEN2;
                                    o_out.tx_byte = i_left[7:0] - 8'd1;
                                end else begin
                                    o_fidx = 3'd1;
                                    o_att = (i_ack_lim != 0) ? i_ack_lim : 32'd1;
                                    o_phase = sbhs_pkg::PH_ACK_DUMMY;
                                end
                            end else if (i_fidx == 3'd1) begin
                                if (i_op == sbhs_pkg::OpRead) begin
                                    o_phase = sbhs_pkg::PH_LEN2;
                                    o_fidx = 3'd0;
                                    o_out.tx_byte = i_left[7:0] - 8'd1;
                                end else if (i_op == sbhs_pkg::OpWrite) begin
                                    o_xor = i_left[7:0] - 8'd1;
                                    o_phase = sbhs_pkg::PH_WR_N;
                                    o_out.tx_byte = i_left[7:0] - 8'd1;
                                end else begin
                                    o_xor = '0;
                                    o_out.tx_valid = 1'b0;
                                    o_out.payload_request = 1'b1;
                                    o_phase = sbhs_pkg::PH_WAIT_PAY;
                                end
                            end else begin
                                o_phase = sbhs_pkg::PH_PRE_DUMMY;
                            end
                        end
                        sbhs_pkg::PH_ACK_NAK, sbhs_pkg::PH_ACK_TMO: begin
                            o_out.tx_valid = 1'b0;
                            o_out.done_res = 1'b1;
                            o_out.status = !last ? sbhs_pkg::StErr
                                         : (i_phase == sbhs_pkg::PH_ACK_NAK)
                                           ? sbhs_pkg::StErr : sbhs_pkg::StTmo;
                            o_phase = sbhs_pkg::PH_IDLE;
                        end
                        sbhs_pkg::PH_PRE_DUMMY: begin
                            if (i_op == sbhs_pkg::OpVersion) o_left = 9'd1;
                            o_phase = (i_op == sbhs_pkg::OpRead || i_op == sbhs_pkg::OpVersion)
                                      ? sbhs_pkg::PH_DATA_RX : sbhs_pkg::PH_CNT_RX;
                        end
                        sbhs_pkg::PH_CNT_RX: begin
                            o_out.read_valid = 1'b1;
                            o_out.read_byte = rx;
                            o_left = {1'b0, rx} + 9'd1;
                            o_phase = sbhs_pkg::PH_DATA_RX;
                        end
                        sbhs_pkg::PH_DATA_RX: begin
                            o_out.read_valid = 1'b1;
                            o_out.read_byte = rx;
                            if (i_left > 9'd1) begin
                                o_left = i_left - 9'd1;
                            end else begin
                                o_left = 9'd0;
                                if (i_op == sbhs_pkg::OpRead) begin
                                    o_out.tx_valid = 1'b0;
                                    o_out.done_res = 1'b1;
                                    o_out.status = sbhs_pkg::StOk;
                                    o_phase = sbhs_pkg::PH_IDLE;
                                end else begin
                                    o_fidx = 3'd1;
                                    o_att = (i_ack_lim != 0) ? i_ack_lim : 32'd1;
                                    o_phase = sbhs_pkg::PH_ACK_DUMMY;
                                end
                            end
                        end
                        sbhs_pkg::PH_WR_N: begin
                            o_out.tx_valid = 1'b0;
                            o_out.payload_request = 1'b1;
                            o_phase = sbhs_pkg::PH_WAIT_PAY;
                        end
                        sbhs_pkg::PH_PG_HI: begin
                            o_phase = sbhs_pkg::PH_PG_LO;
                            o_out.tx_byte = i_addr[7:0];
                        end
                        sbhs_pkg::PH_WR_DATA, sbhs_pkg::PH_PG_LO: begin
                            if (i_left > 9'd1) begin
                                o_left = i_left - 9'd1;
                                o_out.tx_valid = 1'b0;
                                o_out.payload_request = 1'b1;
                                o_phase = sbhs_pkg::PH_WAIT_PAY;
                            end else begin
                                o_left = 9'd0;
                                o_phase = sbhs_pkg::PH_CSUM;
                                o_out.tx_byte = i_xor;
                            end
                        end
                        sbhs_pkg::PH_CSUM: begin
                            o_fidx = 3'd2;
                            o_att = (i_ack_lim != 0) ? i_ack_lim : 32'd1;
                            o_phase = sbhs_pkg::PH_ACK_DUMMY;
                        end
                        default: o_has = 1'b0;
                    endcase
                end
            end
            default: o_has = 1'b0;
        endcase
    end
endmodule

### hw/rtl/spi_bootloader_host_sequencer_unit.sv
// Top level of the SPI bootloader host sequencer: input register, state,
// result register. Depends on sbhs_pkg, sbhs_if and sbhs_core.
//
//  channel  | dir | payload      | handshake
//  in_ch    | in  | t_in_item    | valid/ready
//  out_ch   | out | t_out_item   | valid/ready
//  cfg      | in  | idx, 32b data| write enable
//
// One transaction per cycle while the result register is not stalled: an item
// is registered, then the state update and its result are formed combinationally and land in the result register.
// Synchronous active-low reset clears state and loads the limit registers with defaults.
// A stalled result blocks intake only while both the result and input
// registers are full.
module spi_bootloader_host_sequencer_unit #(
    parameter int unsigned MAX_TRANSFER = sbhs_pkg::MaxTransfer
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    sbhs_if.sink        in_ch,
    sbhs_if.source      out_ch
);
    logic                r_in_v;
    sbhs_pkg::t_in_item  r_in;
    logic                r_out_v;
    sbhs_pkg::t_out_item r_out;
    sbhs_pkg::t_phase    r_phase;
    logic [3:0]          r_op;
    logic [31:0]         r_addr;
    logic [8:0]          r_left;
    logic [2:0]          r_fidx;
    logic [7:0]          r_xor;
    logic [31:0]         r_att;
    logic [31:0]         r_ack_lim;
    logic [31:0]         r_conn_lim;

    sbhs_pkg::t_phase    n_phase;
    logic [3:0]          n_op;
    logic [31:0]         n_addr;
    logic [8:0]          n_left;
    logic [2:0]          n_fidx;
    logic [7:0]          n_xor;
    logic [31:0]         n_att;
    logic                n_has;
    sbhs_pkg::t_out_item n_out;

    logic proc;
    logic in_take;

    sbhs_core #(.MAX_TRANSFER(MAX_TRANSFER)) u_core (
        .i_item(r_in), .i_phase(r_phase), .i_op(r_op), .i_addr(r_addr),
        .i_left(r_left), .i_fidx(r_fidx), .i_xor(r_xor), .i_att(r_att),
        .i_ack_lim(r_ack_lim), .i_conn_lim(r_conn_lim),
        .o_phase(n_phase), .o_op(n_op), .o_addr(n_addr), .o_left(n_left),
        .o_fidx(n_fidx), .o_xor(n_xor), .o_att(n_att), .o_has(n_has), .o_out(n_out)
    );

    assign proc = r_in_v && (!r_out_v || out_ch.ready);
    assign in_take = in_ch.valid && in_ch.ready;
    assign in_ch.ready = !r_in_v || proc;
    assign out_ch.valid = r_out_v;
    assign out_ch.data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
            r_out_v <= 1'b0;
            r_phase <= sbhs_pkg::PH_IDLE;
            r_op <= '0;
            r_addr <= '0;
            r_left <= '0;
            r_fidx <= '0;
            r_xor <= '0;
            r_att <= '0;
            r_ack_lim <= 32'hFFFF_FFFF;
            r_conn_lim <= 32'd1000;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == sbhs_pkg::CfgAckLimit) r_ack_lim <= i_cfg_data;
                else r_conn_lim <= i_cfg_data;
            end
            if (in_take) begin
                r_in_v <= 1'b1;
                r_in <= in_ch.data;
            end else if (proc) begin
                r_in_v <= 1'b0;
            end
            if (proc) begin
                r_phase <= n_phase;
                r_op <= n_op;
                r_addr <= n_addr;
                r_left <= n_left;
                r_fidx <= n_fidx;
                r_xor <= n_xor;
                r_att <= n_att;
                r_out_v <= n_has;
                r_out <= n_out;
            end else if (out_ch.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end
endmodule
